// ===== sv/xfd_pkg.sv =====
// Package with the frame constants, status codes and word types of the deframer.
`default_nettype none

package xfd_pkg;

	localparam int unsigned FRAME_LEN = 19;

	localparam logic [7:0] HEAD_BYTE = 8'hAA;
	localparam logic [7:0] TAIL_BYTE = 8'h55;

	localparam logic [7:0] CMD_POS   = 8'd1;
	localparam logic [7:0] X_POS     = 8'd4;
	localparam logic [7:0] Y_POS     = 8'd8;
	localparam logic [7:0] FLAG_POS  = 8'd12;
	localparam logic [7:0] TIME_POS  = 8'd13;
	localparam logic [7:0] COUNT_MAX = 8'd255;

	localparam logic [7:0] FRAME_LEN_B = 8'(FRAME_LEN);
	localparam logic [7:0] XOR_LAST    = 8'(FRAME_LEN - 3);
	localparam logic [7:0] CSUM_POS    = 8'(FRAME_LEN - 2);
	localparam logic [7:0] LAST_POS    = 8'(FRAME_LEN - 1);

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LEN  = 2'd1,
		ST_HEAD = 2'd2,
		ST_CSUM = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_chunk;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  command;
		logic [31:0] target_x_bits;
		logic [31:0] target_y_bits;
		logic [7:0]  flag_byte;
		logic [31:0] target_time_bits;
	} out_word_t;

endpackage

`default_nettype wire

// ===== sv/xfd_if.sv =====
// Handshake interfaces for the received byte channel and the result channel.
`default_nettype none

interface xfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_chunk;

	modport source(output valid, rx_byte, end_of_chunk, input ready);
	modport sink(input valid, rx_byte, end_of_chunk, output ready);
endinterface

interface xfd_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  command;
	logic [31:0] target_x_bits;
	logic [31:0] target_y_bits;
	logic [7:0]  flag_byte;
	logic [31:0] target_time_bits;

	modport source(output valid, status, command, target_x_bits, target_y_bits,
		flag_byte, target_time_bits, input ready);
	modport sink(input valid, status, command, target_x_bits, target_y_bits,
		flag_byte, target_time_bits, output ready);
endinterface

`default_nettype wire

// ===== sv/xfd_check.sv =====
// Frame state, field capture and status decision for one received word.
`default_nettype none

module xfd_check (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire xfd_pkg::in_word_t word,
	output logic                   res_valid,
	output xfd_pkg::out_word_t     res
);

	logic [7:0]  count_q;
	logic [7:0]  xor_q;
	logic        head_q;
	logic [7:0]  csum_q;
	logic [7:0]  cmd_q;
	logic [31:0] x_q;
	logic [31:0] y_q;
	logic [7:0]  flag_q;
	logic [31:0] time_q;

	logic [1:0]       time_lane;
	xfd_pkg::status_t status;

	assign time_lane = 2'(count_q - xfd_pkg::TIME_POS);

	always_comb begin
		if (count_q != xfd_pkg::LAST_POS) begin
			status = xfd_pkg::ST_LEN;
		end else if (!head_q || word.rx_byte != xfd_pkg::TAIL_BYTE) begin
			status = xfd_pkg::ST_HEAD;
		end else if (xor_q != csum_q) begin
			status = xfd_pkg::ST_CSUM;
		end else begin
			status = xfd_pkg::ST_OK;
		end
	end

	assign res_valid = en && word.end_of_chunk;

	always_comb begin
		res.status = status;
		if (status == xfd_pkg::ST_OK) begin
			res.command          = cmd_q;
			res.target_x_bits    = x_q;
			res.target_y_bits    = y_q;
			res.flag_byte        = flag_q;
			res.target_time_bits = time_q;
		end else begin
			res.command          = '0;
			res.target_x_bits    = '0;
			res.target_y_bits    = '0;
			res.flag_byte        = '0;
			res.target_time_bits = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			xor_q   <= '0;
			head_q  <= 1'b0;
			csum_q  <= '0;
			cmd_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			flag_q  <= '0;
			time_q  <= '0;
		end else if (en) begin
			if (count_q < xfd_pkg::FRAME_LEN_B) begin
				if (count_q == 8'd0) begin
					head_q <= (word.rx_byte == xfd_pkg::HEAD_BYTE);
				end
				if (count_q >= 8'd1 && count_q <= xfd_pkg::XOR_LAST) begin
					xor_q <= xor_q ^ word.rx_byte;
				end
				if (count_q == xfd_pkg::CSUM_POS) begin
					csum_q <= word.rx_byte;
				end
				if (count_q == xfd_pkg::CMD_POS) begin
					cmd_q <= word.rx_byte;
				end
				if (count_q >= xfd_pkg::X_POS && count_q < xfd_pkg::X_POS + 8'd4) begin
					x_q[count_q[1:0]*8 +: 8] <= word.rx_byte;
				end
				if (count_q >= xfd_pkg::Y_POS && count_q < xfd_pkg::Y_POS + 8'd4) begin
					y_q[count_q[1:0]*8 +: 8] <= word.rx_byte;
				end
				if (count_q == xfd_pkg::FLAG_POS) begin
					flag_q <= word.rx_byte;
				end
				if (count_q >= xfd_pkg::TIME_POS && count_q < xfd_pkg::TIME_POS + 8'd4) begin
					time_q[time_lane*8 +: 8] <= word.rx_byte;
				end
			end
			if (word.end_of_chunk) begin
				count_q <= '0;
				xor_q   <= '0;
				head_q  <= 1'b0;
				csum_q  <= '0;
			end else if (count_q != xfd_pkg::COUNT_MAX) begin
				count_q <= count_q + 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/xor_frame_deframer.sv =====
// Top level of the fixed-length frame deframer with XOR checksum.
//
// Channel  Role    Payload
// rx       sink    rx_byte, end_of_chunk
// result   source  status, command, target_x_bits, target_y_bits, flag_byte,
//                  target_time_bits
//
// One word is taken every cycle unless a stalled result holds rx.
// The word passes an input register, then the frame logic updates its state and
// loads the result register at the same edge; the result leaves from there.
// Reset clears the frame count, the checksum state and both valid flags.
// A stalled result holds the input register, which then stalls rx.
`default_nettype none

module xor_frame_deframer (
	input  wire logic clk,
	input  wire logic arst_n,
	xfd_in_if.sink    rx,
	xfd_out_if.source result
);

	logic                valid_s1;
	xfd_pkg::in_word_t   word_s1;
	logic                out_valid_q;
	xfd_pkg::out_word_t  out_q;

	logic                out_free;
	logic                en;
	logic                res_valid;
	xfd_pkg::out_word_t  res;

	assign out_free = !out_valid_q || result.ready;
	assign en       = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			word_s1.rx_byte      <= rx.rx_byte;
			word_s1.end_of_chunk <= rx.end_of_chunk;
		end
	end

	xfd_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.word      (word_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.status           = out_q.status;
	assign result.command          = out_q.command;
	assign result.target_x_bits    = out_q.target_x_bits;
	assign result.target_y_bits    = out_q.target_y_bits;
	assign result.flag_byte        = out_q.flag_byte;
	assign result.target_time_bits = out_q.target_time_bits;

endmodule

`default_nettype wire

// ===== bench/xor_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the frame deframer: directed and random chunks checked against a predictor.

package xfd_tb_pkg;
	import xfd_pkg::*;

	class frame_scoreboard;
		logic [7:0]  pos_count;
		logic [7:0]  xor_acc;
		logic [7:0]  csum_seen;
		bit          head_ok;
		logic [7:0]  cmd_held;
		logic [31:0] x_held;
		logic [31:0] y_held;
		logic [7:0]  flag_held;
		logic [31:0] time_held;
		out_word_t   expected_results[$];
		int          mismatches;
		int          status_tally[4];

		function new();
			pos_count = '0;
			xor_acc = '0;
			csum_seen = '0;
			head_ok = 1'b0;
			cmd_held = '0;
			x_held = '0;
			y_held = '0;
			flag_held = '0;
			time_held = '0;
			mismatches = 0;
			foreach (status_tally[i])
				status_tally[i] = 0;
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function void note_byte(in_word_t w);
			logic [7:0] idx;
			logic [7:0] b;
			out_word_t  r;
			idx = pos_count;
			b = w.rx_byte;
			if (idx < FRAME_LEN_B) begin
				if (idx == 0)
					head_ok = (b == HEAD_BYTE);
				if (idx >= 1 && idx <= XOR_LAST)
					xor_acc ^= b;
				if (idx == CSUM_POS)
					csum_seen = b;
				if (idx == CMD_POS)
					cmd_held = b;
				if (idx >= X_POS && idx < X_POS + 4)
					x_held[8 * (idx - X_POS) +: 8] = b;
				if (idx >= Y_POS && idx < Y_POS + 4)
					y_held[8 * (idx - Y_POS) +: 8] = b;
				if (idx == FLAG_POS)
					flag_held = b;
				if (idx >= TIME_POS && idx < TIME_POS + 4)
					time_held[8 * (idx - TIME_POS) +: 8] = b;
			end
			if (!w.end_of_chunk) begin
				if (pos_count != COUNT_MAX)
					pos_count++;
				return;
			end
			r = '0;
			if (idx != LAST_POS) begin
				r.status = ST_LEN;
			end else if (!head_ok || b != TAIL_BYTE) begin
				r.status = ST_HEAD;
			end else if (xor_acc != csum_seen) begin
				r.status = ST_CSUM;
			end else begin
				r.status = ST_OK;
				r.command = cmd_held;
				r.target_x_bits = x_held;
				r.target_y_bits = y_held;
				r.flag_byte = flag_held;
				r.target_time_bits = time_held;
			end
			expected_results.push_back(r);
			status_tally[r.status]++;
			pos_count = '0;
			xor_acc = '0;
			head_ok = 1'b0;
			csum_seen = '0;
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			mismatches++;
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, got %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status)
				report("status", 32'(want.status), 32'(got.status));
			if (got.command !== want.command)
				report("command", 32'(want.command), 32'(got.command));
			if (got.target_x_bits !== want.target_x_bits)
				report("target_x_bits", want.target_x_bits, got.target_x_bits);
			if (got.target_y_bits !== want.target_y_bits)
				report("target_y_bits", want.target_y_bits, got.target_y_bits);
			if (got.flag_byte !== want.flag_byte)
				report("flag_byte", 32'(want.flag_byte), 32'(got.flag_byte));
			if (got.target_time_bits !== want.target_time_bits)
				report("target_time_bits", want.target_time_bits, got.target_time_bits);
		endfunction
	endclass

endpackage

module xor_frame_deframer_tb;
	import xfd_pkg::*;
	import xfd_tb_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 8;
	localparam int MAX_GAP = 14;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam int WORD_TARGET = 1100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xfd_in_if  rx_if ();
	xfd_out_if res_if ();

	xor_frame_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if)
	);

	frame_scoreboard board = new();

	bit source_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	bit hold_request = 1'b0;
	int words_sent = 0;
	int chunks_sent = 0;
	int stall_cycles = 0;

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a transfer.", stall_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int        gap;
		out_word_t got;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_request) begin
				res_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			gap = sink_quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				res_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			res_if.ready = 1'b1;
			do @(posedge clk); while (!res_if.valid);
			got.status = status_t'(res_if.status);
			got.command = res_if.command;
			got.target_x_bits = res_if.target_x_bits;
			got.target_y_bits = res_if.target_y_bits;
			got.flag_byte = res_if.flag_byte;
			got.target_time_bits = res_if.target_time_bits;
			board.check_result(got);
			@(negedge clk);
		end
	end

	task automatic send_word(input logic [7:0] value, input logic last);
		int       gap;
		in_word_t w;
		gap = source_quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			rx_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid = 1'b1;
		rx_if.rx_byte = value;
		rx_if.end_of_chunk = last;
		do @(posedge clk); while (!rx_if.ready);
		w.rx_byte = value;
		w.end_of_chunk = last;
		board.note_byte(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_chunk(input logic [7:0] words[$]);
		foreach (words[i])
			send_word(words[i], i == words.size() - 1);
		chunks_sent++;
	endtask

	task automatic wait_for_drain();
		rx_if.valid = 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void make_frame(output logic [7:0] f[$], input logic [7:0] cmd,
		input logic [31:0] x, input logic [31:0] y, input logic [7:0] flag,
		input logic [31:0] tm);
		logic [7:0] sum;
		f = {};
		f.push_back(HEAD_BYTE);
		f.push_back(cmd);
		f.push_back(8'($urandom));
		f.push_back(8'($urandom));
		for (int i = 0; i < 4; i++)
			f.push_back(x[8 * i +: 8]);
		for (int i = 0; i < 4; i++)
			f.push_back(y[8 * i +: 8]);
		f.push_back(flag);
		for (int i = 0; i < 4; i++)
			f.push_back(tm[8 * i +: 8]);
		sum = '0;
		for (int i = 1; i <= int'(XOR_LAST); i++)
			sum ^= f[i];
		f.push_back(sum);
		f.push_back(TAIL_BYTE);
	endfunction

	function automatic void random_frame(output logic [7:0] f[$]);
		make_frame(f, 8'($urandom), $urandom, $urandom, 8'($urandom), $urandom);
	endfunction

	function automatic logic [7:0] nonzero_mask();
		return 8'($urandom_range(1, 255));
	endfunction

	initial begin
		logic [7:0] f[$];
		int         kind;
		int         chunk_no;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		rx_if.end_of_chunk = 1'b0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		f = {8'hFF};
		send_chunk(f);
		make_frame(f, 8'h00, 32'h0, 32'h0, 8'h00, 32'h0);
		send_chunk(f);
		make_frame(f, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		send_chunk(f);
		random_frame(f);
		f[0] = 8'h00;
		send_chunk(f);
		random_frame(f);
		f[LAST_POS] = 8'hFF;
		send_chunk(f);
		random_frame(f);
		f[CSUM_POS] ^= 8'h01;
		send_chunk(f);
		random_frame(f);
		f[0] = TAIL_BYTE;
		f[CSUM_POS] ^= 8'h80;
		send_chunk(f);
		random_frame(f);
		f[LAST_POS] = HEAD_BYTE;
		f[CSUM_POS] ^= 8'h10;
		send_chunk(f);
		random_frame(f);
		void'(f.pop_back());
		send_chunk(f);
		random_frame(f);
		f.push_back(TAIL_BYTE);
		send_chunk(f);
		random_frame(f);
		send_chunk(f);

		chunk_no = 0;
		while (words_sent < WORD_TARGET) begin
			chunk_no++;
			if ($urandom_range(0, 7) == 0)
				source_quiet = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0)
				sink_quiet = ($urandom_range(0, 3) == 0);
			if (chunk_no == 8) begin
				source_quiet = 1'b1;
				hold_request = 1'b1;
				repeat (4) begin
					random_frame(f);
					send_chunk(f);
				end
				source_quiet = 1'b0;
			end
			if (chunk_no == 20)
				wait_for_drain();
			if (chunk_no == 30) begin
				// The count must hold at its top value, so a frame past wraparound is still too long.
				f = {};
				repeat (256) f.push_back(8'($urandom));
				begin
					logic [7:0] g[$];
					random_frame(g);
					f = {f, g};
				end
				send_chunk(f);
			end
			kind = $urandom_range(0, 99);
			random_frame(f);
			if (kind < 50) begin
			end else if (kind < 60) begin
				f[$urandom_range(1, CSUM_POS)] ^= nonzero_mask();
			end else if (kind < 67) begin
				f[0] ^= nonzero_mask();
				if ($urandom_range(0, 1) == 1)
					f[CSUM_POS] ^= nonzero_mask();
			end else if (kind < 74) begin
				f[LAST_POS] ^= nonzero_mask();
			end else if (kind < 82) begin
				f = f[0:$urandom_range(0, FRAME_LEN - 2)];
			end else if (kind < 90) begin
				repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
			end else begin
				f = {};
				repeat ($urandom_range(1, 2 * FRAME_LEN)) f.push_back(8'($urandom));
			end
			send_chunk(f);
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d words in %0d chunks, with a saturating chunk, a long result stall and a drain pause.",
			words_sent, chunks_sent);
		$display("Statuses predicted: ok %0d, wrong length %0d, bad head or tail %0d, checksum %0d.",
			board.status_tally[ST_OK], board.status_tally[ST_LEN],
			board.status_tally[ST_HEAD], board.status_tally[ST_CSUM]);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
